/* sv/acls_pkg.sv */
package acls_pkg;

   localparam logic [31:0] TAG_NONE = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      CMD_FIND   = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_ALLOC  = 2'd2,
      CMD_PLACE  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      COH_NONE       = 3'd0,
      COH_EXCLUSIVE  = 3'd1,
      COH_SHARED     = 3'd2,
      COH_SHARED_MOD = 3'd3,
      COH_MODIFIED   = 3'd4
   } coh_type;

   typedef struct packed {
      logic [31:0] tag;
      logic [31:0] word;
      logic [2:0]  state;
      logic        valid;
   } line_type;

   localparam line_type RESET_LINE = '{tag: TAG_NONE, word: 32'd0,
                                       state: COH_NONE, valid: 1'b0};

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_FINISH
   } fsm_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic done;
      logic out_free;
   } sts_type;

endpackage

/* sv/acls_ctrl.sv */
module acls_ctrl
   import acls_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output ctl_type ctl
);

   fsm_type state_ff;
   fsm_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_valid) state_in = FSM_SCAN;
         end
         FSM_SCAN: begin
            if (sts.done) state_in = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (sts.out_free) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            req_stall = 1'b0;
            ctl.start = req_valid;
         end
         FSM_SCAN: begin
            ctl.scan = 1'b1;
         end
         FSM_FINISH: begin
            ctl.commit = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

/* sv/acls_dp.sv */
module acls_dp
   import acls_pkg::*;
#(
   parameter int LINES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_type     ctl,
   output sts_type     sts,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_tag_in,
   input  logic [31:0] req_data_in,
   input  logic [2:0]  req_state_in,
   input  logic        req_valid_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [31:0] rsp_tag_out,
   output logic [31:0] rsp_data_out,
   output logic [2:0]  rsp_state_out,
   output logic        rsp_valid_out,
   output logic [3:0]  rsp_slot,
   output logic        rsp_place_error
);

   localparam int IW = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int CW = $clog2(LINES + 1);

   line_type         mem [LINES];
   logic [LINES-1:0] wr_ff;

   cmd_type          cmd_ff;
   line_type         req_ff;

   logic [CW-1:0]    issue_ff;
   logic             pend_ff;
   line_type         rd_line_ff;
   logic             rd_ok_ff;
   logic [IW-1:0]    rd_idx_ff;

   logic             found_ff;
   logic [IW-1:0]    idx_ff;
   line_type         line_ff;

   logic             out_valid_ff;
   logic             hit_ff;
   line_type         out_line_ff;
   logic [3:0]       slot_ff;
   logic             err_ff;

   logic             issue_more;
   line_type         rd_eff;
   logic             match;
   logic             last;
   logic             hit_now;
   logic             miss_now;
   logic             wr_en;
   logic [IW+3:0]    idx_ext;
   logic             hit_in;
   line_type         out_line_in;
   logic [3:0]       slot_in;
   logic             err_in;

   assign issue_more = (issue_ff < CW'(LINES));
   assign rd_eff     = rd_ok_ff ? rd_line_ff : RESET_LINE;
   assign last       = (rd_idx_ff == IW'(LINES - 1));

   always_comb begin
      case (cmd_ff)
         CMD_FIND:   match = (rd_eff.tag == req_ff.tag) && (rd_eff.state != COH_NONE);
         CMD_LOOKUP: match = (rd_eff.tag == req_ff.tag);
         CMD_ALLOC:  match = !rd_eff.valid;
         CMD_PLACE:  match = (rd_eff.tag == req_ff.tag);
         default:    match = 1'b0;
      endcase
   end

   assign hit_now  = ctl.scan && pend_ff && match;
   assign miss_now = ctl.scan && pend_ff && !match && last;

   assign sts.done     = hit_now || miss_now;
   assign sts.out_free = !out_valid_ff || !rsp_stall;

   assign wr_en   = (cmd_ff == CMD_ALLOC) || ((cmd_ff == CMD_PLACE) && found_ff);
   assign idx_ext = {4'd0, idx_ff};

   always_comb begin
      hit_in      = 1'b0;
      out_line_in = RESET_LINE;
      slot_in     = 4'd0;
      err_in      = 1'b0;
      case (cmd_ff)
         CMD_FIND, CMD_LOOKUP: begin
            if (found_ff) begin
               hit_in      = 1'b1;
               out_line_in = line_ff;
            end
         end
         CMD_ALLOC: begin
            slot_in = idx_ext[3:0];
         end
         CMD_PLACE: begin
            if (found_ff) slot_in = idx_ext[3:0];
            else          err_in  = 1'b1;
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cmd_ff <= cmd_type'(req_cmd);
         req_ff <= '{tag: req_tag_in, word: req_data_in,
                     state: req_state_in, valid: req_valid_in};
      end
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else if (ctl.start) begin
         issue_ff <= '0;
         pend_ff  <= 1'b0;
      end else if (ctl.scan) begin
         if (issue_more) issue_ff <= issue_ff + CW'(1);
         pend_ff <= issue_more && !sts.done;
      end
   end

   // line store; unwritten lines read as the reset line
   always_ff @(posedge clock) begin
      if (ctl.scan && issue_more) begin
         rd_line_ff <= mem[issue_ff[IW-1:0]];
         rd_ok_ff   <= wr_ff[issue_ff[IW-1:0]];
         rd_idx_ff  <= issue_ff[IW-1:0];
      end
      if (ctl.commit && wr_en) begin
         mem[idx_ff] <= req_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
      end else if (ctl.commit && wr_en) begin
         wr_ff[idx_ff] <= 1'b1;
      end
   end

   // hold the scan outcome
   always_ff @(posedge clock) begin
      if (hit_now) begin
         found_ff <= 1'b1;
         idx_ff   <= rd_idx_ff;
         line_ff  <= rd_eff;
      end else if (miss_now) begin
         found_ff <= 1'b0;
         idx_ff   <= '0;
         line_ff  <= RESET_LINE;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ctl.commit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         hit_ff      <= hit_in;
         out_line_ff <= out_line_in;
         slot_ff     <= slot_in;
         err_ff      <= err_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_tag_out     = out_line_ff.tag;
   assign rsp_data_out    = out_line_ff.word;
   assign rsp_state_out   = out_line_ff.state;
   assign rsp_valid_out   = out_line_ff.valid;
   assign rsp_slot        = slot_ff;
   assign rsp_place_error = err_ff;

endmodule

/* sv/assoc_cache_line_store.sv */
// Fully associative line store with LINES entries of tag, data, coherence
// state and valid bit.
// req_ channel: one command item (find, lookup, allocate, place) with the
// line fields; accepted when req_valid is high and req_stall is low.
// rsp_ channel: exactly one result item per command, in command order.
// Each command walks the lines one per cycle through a registered memory
// read port, stopping at the first match. The outcome is held, then the
// result is committed to the output register together with any line write,
// and only then is a new command accepted. The result sits in an output
// register, so a new command is accepted while an earlier result is still
// waiting.
// If rsp_stall holds the output register full, the finishing command waits
// (and its line write with it) until the register drains.
// Reset is synchronous: every line reads as tag all ones, data zero, state
// none and valid zero right after reset, with no clearing pass; the output
// register is emptied.
module assoc_cache_line_store
   import acls_pkg::*;
#(
   parameter int LINES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_tag_in,
   input  logic [31:0] req_data_in,
   input  logic [2:0]  req_state_in,
   input  logic        req_valid_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit,
   output logic [31:0] rsp_tag_out,
   output logic [31:0] rsp_data_out,
   output logic [2:0]  rsp_state_out,
   output logic        rsp_valid_out,
   output logic [3:0]  rsp_slot,
   output logic        rsp_place_error
);

   ctl_type ctl;
   sts_type sts;

   acls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl)
   );

   acls_dp #(
      .LINES (LINES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_cmd         (req_cmd),
      .req_tag_in      (req_tag_in),
      .req_data_in     (req_data_in),
      .req_state_in    (req_state_in),
      .req_valid_in    (req_valid_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_data_out    (rsp_data_out),
      .rsp_state_out   (rsp_state_out),
      .rsp_valid_out   (rsp_valid_out),
      .rsp_slot        (rsp_slot),
      .rsp_place_error (rsp_place_error)
   );

endmodule

/* dv/tb_assoc_cache_line_store.sv */
module tb_assoc_cache_line_store;
   import acls_pkg::*;

   localparam int LINES_N        = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LINES   = 50;

   typedef struct packed {
      logic        hit;
      logic [31:0] tag;
      logic [31:0] data;
      logic [2:0]  state;
      logic        valid;
      logic [3:0]  slot;
      logic        place_error;
   } answer_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_RANDOM,
      RX_PERIODIC,
      RX_HEAVY
   } rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_FIND;
   logic [31:0] req_tag_in = 32'd0;
   logic [31:0] req_data_in = 32'd0;
   logic [2:0]  req_state_in = COH_NONE;
   logic        req_valid_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_hit;
   logic [31:0] rsp_tag_out;
   logic [31:0] rsp_data_out;
   logic [2:0]  rsp_state_out;
   logic        rsp_valid_out;
   logic [3:0]  rsp_slot;
   logic        rsp_place_error;

   line_type    mirror_lines [LINES_N];
   answer_type  pending_answers [$];
   logic [31:0] tag_pool [8];
   int          mismatch_count = 0;
   int          burst_left = 0;
   int          quiet_cycles = 0;
   int          stall_tick = 0;
   rx_mode_type rx_mode = RX_OPEN;

   assoc_cache_line_store #(.LINES(LINES_N)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_tag_in      (req_tag_in),
      .req_data_in     (req_data_in),
      .req_state_in    (req_state_in),
      .req_valid_in    (req_valid_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_tag_out     (rsp_tag_out),
      .rsp_data_out    (rsp_data_out),
      .rsp_state_out   (rsp_state_out),
      .rsp_valid_out   (rsp_valid_out),
      .rsp_slot        (rsp_slot),
      .rsp_place_error (rsp_place_error)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mirror of the line store; updated in command order at accept time.
   function automatic answer_type predict_access(cmd_type cmd, logic [31:0] tag,
                                                 logic [31:0] data, logic [2:0] state,
                                                 logic valid);
      answer_type ans;
      int         match_at;
      int         free_at;
      ans = '{hit: 1'b0, tag: TAG_NONE, data: 32'd0, state: COH_NONE, valid: 1'b0,
              slot: 4'd0, place_error: 1'b0};
      match_at = -1;
      free_at  = -1;
      for (int k = 0; k < LINES_N; k++) begin
         if (match_at < 0 && mirror_lines[k].tag == tag &&
             (cmd != CMD_FIND || mirror_lines[k].state != COH_NONE))
            match_at = k;
         if (free_at < 0 && !mirror_lines[k].valid)
            free_at = k;
      end
      case (cmd)
         CMD_FIND, CMD_LOOKUP: begin
            if (match_at >= 0) begin
               ans.hit   = 1'b1;
               ans.tag   = mirror_lines[match_at].tag;
               ans.data  = mirror_lines[match_at].word;
               ans.state = mirror_lines[match_at].state;
               ans.valid = mirror_lines[match_at].valid;
            end
         end
         CMD_ALLOC: begin
            // a full store evicts line 0
            if (free_at < 0)
               free_at = 0;
            mirror_lines[free_at] = '{tag: tag, word: data, state: state, valid: valid};
            ans.slot = 4'(free_at);
         end
         default: begin
            if (match_at >= 0) begin
               mirror_lines[match_at] = '{tag: tag, word: data, state: state, valid: valid};
               ans.slot = 4'(match_at);
            end else begin
               ans.place_error = 1'b1;
            end
         end
      endcase
      return ans;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < REPORT_LINES)
         $display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
      mismatch_count++;
   endtask

   // Call at a rising edge; returns at the edge that accepted the item.
   task automatic issue_command(cmd_type cmd, logic [31:0] tag, logic [31:0] data,
                                logic [2:0] state, logic valid);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_tag_in   <= tag;
      req_data_in  <= data;
      req_state_in <= state;
      req_valid_in <= valid;
      do @(posedge clock); while (req_stall);
      pending_answers.push_back(predict_access(cmd, tag, data, state, valid));
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_answers.size() != 0)
         @(posedge clock);
   endtask

   task automatic refresh_tag_pool();
      tag_pool[0] = TAG_NONE;
      tag_pool[1] = 32'd0;
      for (int k = 2; k < 8; k++)
         tag_pool[k] = $urandom;
   endtask

   // Mostly reuse a few tags so finds and places hit; sometimes a fresh one.
   function automatic logic [31:0] pick_tag();
      if ($urandom_range(0, 99) < 85)
         return tag_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_state();
      return 3'($urandom_range(0, 7));
   endfunction

   task automatic test_directed_corners();
      logic [31:0] tag;
      // unused lines carry tag all ones: lookup hits, find misses on state none
      issue_command(CMD_LOOKUP, TAG_NONE, 32'd0, COH_NONE, 1'b0);
      issue_command(CMD_FIND, TAG_NONE, 32'd0, COH_NONE, 1'b0);
      issue_command(CMD_PLACE, TAG_NONE, 32'hFFFF_FFFF, COH_EXCLUSIVE, 1'b0);
      issue_command(CMD_FIND, TAG_NONE, 32'd0, COH_NONE, 1'b0);
      issue_command(CMD_PLACE, 32'd0, 32'h1234_5678, COH_MODIFIED, 1'b1);
      // fill every line, walking all states including the undefined ones
      for (int i = 0; i < LINES_N; i++) begin
         tag = (i == 0) ? 32'd0 : {4'(i), 28'h5A5_A5A5};
         issue_command(CMD_ALLOC, tag, (i % 2) ? 32'hFFFF_FFFF : 32'(i), 3'(i), 1'b1);
      end
      issue_command(CMD_ALLOC, 32'hFFFF_FFFE, 32'hA5A5_A5A5, COH_SHARED_MOD, 1'b1);
      issue_command(CMD_FIND, {4'd8, 28'h5A5_A5A5}, 32'd0, COH_NONE, 1'b0);
      issue_command(CMD_LOOKUP, {4'd8, 28'h5A5_A5A5}, 32'd0, COH_NONE, 1'b0);
      issue_command(CMD_PLACE, {4'd15, 28'h5A5_A5A5}, 32'h8000_0001, COH_SHARED, 1'b0);
      issue_command(CMD_ALLOC, 32'h7FFF_FFFF, 32'h0F0F_F0F0, COH_EXCLUSIVE, 1'b1);
      issue_command(CMD_FIND, {4'd7, 28'h5A5_A5A5}, 32'd0, COH_NONE, 1'b1);
   endtask

   task automatic test_pool_traffic(int count);
      int      pick;
      cmd_type cmd;
      refresh_tag_pool();
      repeat (count) begin
         pick = $urandom_range(0, 99);
         cmd  = (pick < 30) ? CMD_FIND : (pick < 50) ? CMD_LOOKUP :
                (pick < 75) ? CMD_ALLOC : CMD_PLACE;
         issue_command(cmd, pick_tag(), $urandom, pick_state(), $urandom_range(0, 3) != 0);
      end
   endtask

   // Free lines by placing them invalid, refill them, then look them up.
   task automatic test_free_and_refill(int rounds);
      refresh_tag_pool();
      repeat (rounds) begin
         repeat (3) issue_command(CMD_PLACE, pick_tag(), $urandom, pick_state(), 1'b0);
         repeat (3) issue_command(CMD_ALLOC, pick_tag(), $urandom, pick_state(), 1'b1);
         repeat (4) issue_command(cmd_type'($urandom_range(0, 1)), pick_tag(), $urandom,
                                  pick_state(), 1'($urandom));
      end
   endtask

   task automatic test_drain_pause();
      test_pool_traffic(75);
      wait_for_answers();
      test_pool_traffic(75);
   endtask

   initial begin
      for (int k = 0; k < LINES_N; k++)
         mirror_lines[k] = RESET_LINE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_pool_traffic(300);
      test_free_and_refill(20);
      test_drain_pause();
      wait_for_answers();
      repeat (LINES_N + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("unexpected item", {31'd0, rsp_valid}, 32'd0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch("hit", 32'(rsp_hit), 32'(want.hit));
            if (rsp_tag_out !== want.tag)
               report_mismatch("tag_out", rsp_tag_out, want.tag);
            if (rsp_data_out !== want.data)
               report_mismatch("data_out", rsp_data_out, want.data);
            if (rsp_state_out !== want.state)
               report_mismatch("state_out", 32'(rsp_state_out), 32'(want.state));
            if (rsp_valid_out !== want.valid)
               report_mismatch("valid_out", 32'(rsp_valid_out), 32'(want.valid));
            if (rsp_slot !== want.slot)
               report_mismatch("slot", 32'(rsp_slot), 32'(want.slot));
            if (rsp_place_error !== want.place_error)
               report_mismatch("place_error", 32'(rsp_place_error),
                               32'(want.place_error));
         end
      end
   end

   // Receiver back-pressure: the stall pattern is switched at random among four modes.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 128 == 0)
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_OPEN:     rsp_stall <= 1'b0;
         RX_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
         RX_PERIODIC: rsp_stall <= (stall_tick % 7) < 3;
         default:     rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

endmodule

/* files.f */
sv/acls_pkg.sv
sv/acls_ctrl.sv
sv/acls_dp.sv
sv/assoc_cache_line_store.sv
dv/tb_assoc_cache_line_store.sv
